/* design/kbq_pkg.sv */
// Package for the keyboard event qualifier.
// Holds the item and state types, the event kind codes and the register indexes.
// No dependencies.
package kbq_pkg;

  localparam int unsigned CharW    = 8;
  localparam int unsigned TimeW    = 63;
  localparam int unsigned HoldW    = 26;
  localparam int unsigned KindW    = 3;
  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned CfgIdxW  = 1;

  // Event kinds.
  localparam logic [KindW-1:0] KIND_NONE = 3'd0;
  localparam logic [KindW-1:0] KIND_CHAR = 3'd1;
  localparam logic [KindW-1:0] KIND_HOLD = 3'd2;
  localparam logic [KindW-1:0] KIND_OPT  = 3'd3;
  localparam logic [KindW-1:0] KIND_ALT  = 3'd4;
  localparam logic [KindW-1:0] KIND_FN   = 3'd5;
  localparam logic [KindW-1:0] KIND_CTRL = 3'd6;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_ENABLED   = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_HOLD_TIME = 1'd1;

  localparam logic [HoldW-1:0] HoldTimeReset = 26'd1000000;

  // Characters substituted for the delete, enter and tab keys.
  localparam logic [CharW-1:0] CHAR_BS = 8'd8;
  localparam logic [CharW-1:0] CHAR_NL = 8'd10;
  localparam logic [CharW-1:0] CHAR_HT = 8'd9;

  // Edge flag bits for the modifier events.
  localparam logic [3:0] FLAG_OPT  = 4'b0001;
  localparam logic [3:0] FLAG_ALT  = 4'b0010;
  localparam logic [3:0] FLAG_FN   = 4'b0100;
  localparam logic [3:0] FLAG_CTRL = 4'b1000;

  typedef struct packed {
    logic [TimeW-1:0] now_us;
    logic             caps_locked;
    logic             alt_key;
    logic             opt_key;
    logic             ctrl_key;
    logic             shift_key;
    logic             fn_key;
    logic             tab_key;
    logic             enter_key;
    logic             delete_key;
    logic [CharW-1:0] word_char;
  } in_item_t;

  typedef struct packed {
    logic             reported;
    logic             out_caps;
    logic             out_alt;
    logic             out_opt;
    logic             out_ctrl;
    logic             out_shift;
    logic             out_fn;
    logic [CharW-1:0] event_char;
    logic [KindW-1:0] event_kind;
  } out_item_t;

  typedef struct packed {
    logic [TimeW-1:0] press_time;
    logic             hold_done;
    logic [CharW-1:0] last_char;
    logic [5:0]       last_char_mods;
    logic [3:0]       last_mod_flags;
  } kbq_state_t;

  typedef struct packed {
    logic             enabled;
    logic [HoldW-1:0] hold_time_us;
  } kbq_cfg_t;

endpackage

/* design/kbq_eval.sv */
// Combinational evaluation of one keyboard snapshot for the event qualifier.
// Produces the result item and the next tracking state from the current one.
// Depends on kbq_pkg.
module kbq_eval import kbq_pkg::*; (
  input  in_item_t   item_i,
  input  kbq_state_t state_i,
  input  kbq_cfg_t   cfg_i,
  output out_item_t  res_o,
  output kbq_state_t state_o
);

  logic [TimeW:0]   elapsed;
  logic             hold_reached;

  // Elapsed time since the press; the top bit flags time going backwards.
  assign elapsed = {1'b0, item_i.now_us} - {1'b0, state_i.press_time};
  assign hold_reached = !elapsed[TimeW] &&
                        ((|elapsed[TimeW-1:HoldW]) || (elapsed[HoldW-1:0] >= cfg_i.hold_time_us));

  always_comb begin
    logic             hold_fire;
    logic [CharW-1:0] ch;
    logic [5:0]       mods;
    logic [3:0]       flag;
    logic [KindW-1:0] kind;

    res_o     = '0;
    state_o   = state_i;
    hold_fire = 1'b0;
    ch        = '0;
    mods      = {item_i.caps_locked, item_i.alt_key, item_i.opt_key,
                 item_i.ctrl_key, item_i.shift_key, item_i.fn_key};
    flag      = '0;
    kind      = KIND_NONE;

    if (cfg_i.enabled) begin
      res_o.out_fn    = item_i.fn_key;
      res_o.out_shift = item_i.shift_key;
      res_o.out_ctrl  = item_i.ctrl_key;
      res_o.out_opt   = item_i.opt_key;
      res_o.out_alt   = item_i.alt_key;
      res_o.out_caps  = item_i.caps_locked;

      if (item_i.delete_key) begin
        if (state_i.press_time == '0) begin
          state_o.press_time = item_i.now_us;
          state_o.hold_done  = 1'b0;
        end else if (!state_i.hold_done && hold_reached) begin
          state_o.hold_done = 1'b1;
          hold_fire         = 1'b1;
        end
      end else begin
        state_o.press_time = '0;
        state_o.hold_done  = 1'b0;
      end

      if (item_i.word_char != '0) begin
        ch = item_i.word_char;
      end else if (item_i.delete_key) begin
        ch = CHAR_BS;
      end else if (item_i.enter_key) begin
        ch = CHAR_NL;
      end else if (item_i.tab_key) begin
        ch = CHAR_HT;
      end

      if (item_i.opt_key) begin
        flag = FLAG_OPT;
        kind = KIND_OPT;
      end else if (item_i.alt_key) begin
        flag = FLAG_ALT;
        kind = KIND_ALT;
      end else if (item_i.fn_key) begin
        flag = FLAG_FN;
        kind = KIND_FN;
      end else if (item_i.ctrl_key) begin
        flag = FLAG_CTRL;
        kind = KIND_CTRL;
      end
      if ((flag & state_i.last_mod_flags) != '0) begin
        kind = KIND_NONE;
      end

      if (hold_fire) begin
        res_o.event_kind = KIND_HOLD;
      end else if (ch != '0) begin
        res_o.event_char       = ch;
        state_o.last_mod_flags = '0;
        // Same character with the same modifiers is suppressed.
        if (!(ch == state_i.last_char && mods == state_i.last_char_mods)) begin
          state_o.last_char      = ch;
          state_o.last_char_mods = mods;
          res_o.event_kind       = KIND_CHAR;
        end
      end else begin
        state_o.last_char      = '0;
        state_o.last_mod_flags = flag;
        res_o.event_kind       = kind;
      end

      res_o.reported = (res_o.event_kind != KIND_NONE);
    end
  end

endmodule

/* design/keyboard_event_qualifier.sv */
// Top level of the keyboard event qualifier: stream ports, configuration
// registers, input register, tracking state and result register.
// Depends on kbq_pkg and kbq_eval.

// Every accepted snapshot gives exactly one result item. Throughput is one
// snapshot per clock cycle while the output side takes each result. A
// result passes from the input register to the result register, and can be
// taken when the output side is ready. Between the two registers,
// combinational logic compares the snapshot with the tracking state and
// updates that state as the result register is loaded. The input side
// stalls only when a result is waiting and the output side is not taking
// it. Configuration (enable and delete hold time in microseconds) is always
// accepted and should be written while no snapshot is in flight. While
// disabled, every result is all zero and the tracking state holds.
module keyboard_event_qualifier import kbq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write channel.
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [HoldW-1:0]    cfg_data_i,
  // Snapshot input stream.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // From bit 0: word_char[7:0], delete_key, enter_key, tab_key, fn_key,
  // shift_key, ctrl_key, opt_key, alt_key, caps_locked, now_us[62:0].
  input  logic [InDataW-1:0]  s_axis_tdata,
  // Event output stream.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // From bit 0: event_char[7:0], out_fn, out_shift, out_ctrl, out_opt,
  // out_alt, out_caps, reported, one zero pad bit.
  output logic [OutDataW-1:0] m_axis_tdata,
  // event_kind[2:0].
  output logic [KindW-1:0]    m_axis_tuser
);

  kbq_cfg_t   cfg_q;
  logic       in_valid_q;
  in_item_t   in_q;
  logic       out_valid_q;
  out_item_t  out_q;
  kbq_state_t state_q;
  kbq_state_t state_d;
  out_item_t  res;
  logic       advance;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled      <= 1'b0;
      cfg_q.hold_time_us <= HoldTimeReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ENABLED:   cfg_q.enabled      <= cfg_data_i[0];
        REG_HOLD_TIME: cfg_q.hold_time_us <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The snapshot in the input register moves on when the result register
  // is free or is being emptied this cycle.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= in_item_t'(s_axis_tdata);
    end
  end

  kbq_eval u_eval (
    .item_i  (in_q),
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .res_o   (res),
    .state_o (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      state_q     <= state_d;
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.event_kind;
  assign m_axis_tdata  = {1'b0, out_q.reported, out_q.out_caps, out_q.out_alt,
                          out_q.out_opt, out_q.out_ctrl, out_q.out_shift,
                          out_q.out_fn, out_q.event_char};

endmodule

/* design/kbq_checker.sv */
// Port-level checks for the keyboard event qualifier, bound to the top level.
// Depends on kbq_pkg.
module kbq_checker import kbq_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [KindW-1:0]    m_axis_tuser
);

  // The reported flag matches the event kind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[14] == (m_axis_tuser != KIND_NONE)))
    else $error("reported flag disagrees with event kind");

  // A character event always carries a character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_CHAR) |-> (m_axis_tdata[7:0] != '0))
    else $error("character event without a character");

  // Hold and modifier events carry no character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == KIND_HOLD || m_axis_tuser == KIND_OPT ||
                       m_axis_tuser == KIND_ALT || m_axis_tuser == KIND_FN ||
                       m_axis_tuser == KIND_CTRL)) |-> (m_axis_tdata[7:0] == '0))
    else $error("non-character event with a character");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind keyboard_event_qualifier kbq_checker u_kbq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
